// File: hdl/adct_pkg.sv
// Shared types and constants for the airtime duty-cycle tracker.
// Holds the controller/datapath command and status structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package adct_pkg;

  // Item kinds carried in tuser
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Field widths
  localparam int NOW_W   = 32;
  localparam int AIR_W   = 16;
  localparam int DUTY_W  = 16;
  localparam int TOTAL_W = 20;
  localparam int HITS_W  = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Constants of the duty-cycle arithmetic
  localparam logic [NOW_W-1:0]   WINDOW_RESET = 32'd3600000;
  localparam int                 SCALE_W      = 15;
  localparam logic [SCALE_W-1:0] DUTY_SCALE   = 15'd25600;  // 100 percent times 256
  localparam logic [DUTY_W-1:0]  DUTY_MAX     = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 20'hFFFFF;
  localparam logic [HITS_W-1:0]  HITS_MAX     = 5'd31;
  localparam logic [4:0]         DIV_STEPS    = 5'd16;

  // Commands from controller to datapath
  typedef struct packed {
    logic rec_write;
    logic query_start;
    logic rd_issue;
    logic mul_load;
    logic div_init;
    logic div_step;
    logic out_load;
  } adct_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ring_empty;
    logic walk_last;
    logic div_last;
    logic out_free;
  } adct_stat_t;

endpackage
`default_nettype wire

// File: hdl/airtime_duty_cycle_tracker_top.sv
// Top level of the sliding-window transmit duty-cycle tracker.
// Instantiates adct_ctrl and adct_datapath; depends on adct_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Keeps the last RECORD_SLOTS transmissions (start time, airtime) in a ring
// memory. A record item (tuser = 0) is written on acceptance and gives no
// result. A query item (tuser = 1) walks the n stored entries, one memory
// read a cycle, sums the airtime of those whose age is at most window_ms,
// then forms total * 25600 / window_ms with a 16-step serial divider; the
// result register is loaded once the output register is free, and the next
// item is taken in the cycle after that load. A result waits in the output
// register, so new record items are accepted meanwhile.
// The duty cycle is Q8.8 percent, floored, saturated at 65535.
module airtime_duty_cycle_tracker_top
  import adct_pkg::*;
#(
  parameter int RECORD_SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write: window_ms
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [NOW_W-1:0]      cfg_data,
  // Input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // now_ms[31:0], airtime_ms[47:32]
  input  wire logic                  s_axis_tuser,   // kind
  // Result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // duty_percent_q8[15:0],
                                                     // airtime_total_ms[35:16],
                                                     // records_in_window[40:36], zeros
);

  adct_cmd_t          cmd;
  adct_stat_t         stat;
  logic [DUTY_W-1:0]  duty;
  logic [TOTAL_W-1:0] total;
  logic [HITS_W-1:0]  hits;

  assign cfg_ready = 1'b1;

  adct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adct_datapath #(
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_now     (s_axis_tdata[NOW_W-1:0]),
    .in_air     (s_axis_tdata[NOW_W+AIR_W-1:NOW_W]),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_window (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_duty   (duty),
    .out_total  (total),
    .out_hits   (hits)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {
    (OUT_DATA_W - DUTY_W - TOTAL_W - HITS_W)'(0), hits, total, duty
  };

endmodule
`default_nettype wire

// File: hdl/adct_ctrl.sv
// Sequencing state machine for the duty-cycle tracker.
// Depends on adct_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module adct_ctrl
  import adct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_kind,
  output logic            in_ready,
  input  wire adct_stat_t stat,
  output adct_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode commands and next state
  always_comb begin
    state_next      = state;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_RECORD) begin
            cmd.rec_write = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_next      = stat.ring_empty ? S_MUL : S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.rd_issue = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/adct_datapath.sv
// Ring memory, window sum, product and serial divider of the duty-cycle tracker.
// Depends on adct_pkg; driven by adct_ctrl through adct_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module adct_datapath
  import adct_pkg::*;
#(
  parameter int RECORD_SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire adct_cmd_t             cmd,
  output adct_stat_t                 stat,
  input  wire logic [NOW_W-1:0]      in_now,
  input  wire logic [AIR_W-1:0]      in_air,
  input  wire logic                  cfg_write,
  input  wire logic [NOW_W-1:0]      cfg_window,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [DUTY_W-1:0]          out_duty,
  output logic [TOTAL_W-1:0]         out_total,
  output logic [HITS_W-1:0]          out_hits
);

  localparam int SLOT_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RECORD_SLOTS + 1);
  localparam int TOT_W  = AIR_W + CNT_W;
  localparam int PROD_W = TOT_W + SCALE_W;
  localparam int HI_W   = PROD_W - 16;
  localparam int CMP_W  = (HI_W > NOW_W) ? HI_W : NOW_W;
  localparam int TSAT_W = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;
  localparam int HSAT_W = (CNT_W > HITS_W) ? CNT_W : HITS_W;

  // Ring storage
  logic [NOW_W-1:0] mem_time [RECORD_SLOTS];
  logic [AIR_W-1:0] mem_air  [RECORD_SLOTS];

  logic [NOW_W-1:0]  window;
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  stored_count;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_valid;
  logic [NOW_W-1:0]  rd_time;
  logic [AIR_W-1:0]  rd_air;
  logic [NOW_W-1:0]  q_now;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  hits;
  logic [PROD_W-1:0] prod;
  logic              sat;
  logic [NOW_W:0]    rem;
  logic [DUTY_W-1:0] quot;
  logic [4:0]        div_cnt;
  logic [NOW_W-1:0]  age;
  logic [NOW_W:0]    trial;
  logic              trial_ok;
  logic [HI_W-1:0]   prod_hi;

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_write) begin
      window <= cfg_window;
    end
  end

  // Write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      stored_count <= '0;
    end else if (cmd.rec_write) begin
      if (write_slot == SLOT_W'(RECORD_SLOTS - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
      if (stored_count != CNT_W'(RECORD_SLOTS)) begin
        stored_count <= stored_count + 1'b1;
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.rec_write) begin
      mem_time[write_slot] <= in_now;
      mem_air[write_slot]  <= in_air;
    end
    rd_time <= mem_time[rd_idx];
    rd_air  <= mem_air[rd_idx];
  end

  // Walk index and read-data flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.query_start) begin
        rd_idx <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  assign age = q_now - rd_time;

  // Accumulate airtime and hits of entries inside the window
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_now <= in_now;
      total <= '0;
      hits  <= '0;
    end else if (rd_valid && (age <= window)) begin
      total <= total + TOT_W'(rd_air);
      hits  <= hits + 1'b1;
    end
  end

  // Scale the sum
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= total * PROD_W'(DUTY_SCALE);
    end
  end

  assign prod_hi  = prod[PROD_W-1:16];
  assign trial    = {rem[NOW_W-1:0], quot[DUTY_W-1]};
  assign trial_ok = trial >= {1'b0, window};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sat     <= CMP_W'(prod_hi) >= CMP_W'(window);
      rem     <= (NOW_W + 1)'(prod_hi);
      quot    <= prod[15:0];
      div_cnt <= DIV_STEPS;
    end else if (cmd.div_step) begin
      rem     <= trial_ok ? (trial - {1'b0, window}) : trial;
      quot    <= {quot[DUTY_W-2:0], trial_ok};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (total == '0) begin
        out_duty <= '0;
      end else if (sat) begin
        out_duty <= DUTY_MAX;
      end else begin
        out_duty <= quot;
      end
      if (TSAT_W'(total) > TSAT_W'(TOTAL_MAX)) begin
        out_total <= TOTAL_MAX;
      end else begin
        out_total <= TOTAL_W'(total);
      end
      if (HSAT_W'(hits) > HSAT_W'(HITS_MAX)) begin
        out_hits <= HITS_MAX;
      end else begin
        out_hits <= HITS_W'(hits);
      end
    end
  end

  // Status back to the controller
  assign stat.ring_empty = (stored_count == '0);
  assign stat.walk_last  = (rd_idx == SLOT_W'(stored_count - 1'b1));
  assign stat.div_last   = (div_cnt == 5'd1);
  assign stat.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

// File: tb/tb_airtime_duty_cycle_tracker_top.sv
// Self-checking testbench for airtime_duty_cycle_tracker_top: random and directed
// record/query items, predicted duty-cycle reports compared field by field.
// Depends on adct_pkg and the tracker RTL only.
`timescale 1ns / 1ps
module tb_airtime_duty_cycle_tracker_top;
  import adct_pkg::*;

  localparam int SLOTS          = 16;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 5000;
  localparam int PHASES         = 7;

  typedef struct packed {
    logic             kind;
    logic [NOW_W-1:0] now;
    logic [AIR_W-1:0] air;
  } tx_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [TOTAL_W-1:0] total;
    logic [HITS_W-1:0]  hits;
  } duty_report_t;

  // Block ports, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NOW_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // now_ms[31:0], airtime_ms[47:32]
  logic                  s_axis_tuser = 1'b0; // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // duty[15:0], total[35:16], hits[40:36]

  // Predictor state: ring contents, fill level and window setting
  logic [NOW_W-1:0] ring_time [SLOTS];
  logic [AIR_W-1:0] ring_air  [SLOTS];
  int               ring_wr   = 0;
  int               ring_fill = 0;
  logic [NOW_W-1:0] win_setting = WINDOW_RESET;

  tx_item_t     pend_q[$];
  duty_report_t duty_reports_q[$];
  tx_item_t     cur_item;

  int src_gap = 0, sink_gap = 0, hold_left = 0;
  int src_idle_pct = 0, sink_idle_pct = 0;
  int hold_reqs = 0, holds_done = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int records_taken = 0, queries_taken = 0, reports_checked = 0;
  int sat_reports = 0, empty_reports = 0, full_ring_reports = 0, windows_tried = 0;
  logic [NOW_W-1:0] clock_ms = '0;

  airtime_duty_cycle_tracker_top #(.RECORD_SLOTS(SLOTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the ring on a record item, or work out the duty report of a query
  task automatic track_duty_item(input tx_item_t it);
    logic [63:0]  sum;
    logic [63:0]  duty;
    logic [31:0]  age;
    int           hits;
    duty_report_t rep;
    if (it.kind == KIND_RECORD) begin
      ring_time[ring_wr] = it.now;
      ring_air[ring_wr]  = it.air;
      ring_wr = (ring_wr + 1) % SLOTS;
      if (ring_fill < SLOTS) ring_fill++;
      records_taken++;
    end else begin
      sum  = '0;
      hits = 0;
      for (int i = 0; i < ring_fill; i++) begin
        age = it.now - ring_time[i];
        if (age <= win_setting) begin
          sum += ring_air[i];
          hits++;
        end
      end
      duty = '0;
      if (hits != 0 && sum != 0) begin
        if (win_setting == '0) begin
          duty = 64'hFFFF;
        end else begin
          duty = (sum * 64'd25600) / {32'b0, win_setting};
          if (duty > 64'hFFFF) duty = 64'hFFFF;
        end
      end
      rep.duty  = duty[DUTY_W-1:0];
      rep.total = (sum > 64'hFFFFF) ? 20'hFFFFF : sum[TOTAL_W-1:0];
      rep.hits  = (hits > 31) ? 5'd31 : HITS_W'(hits);
      duty_reports_q.push_back(rep);
      queries_taken++;
      if (rep.duty == 16'hFFFF) sat_reports++;
      if (hits == 0) empty_reports++;
      if (hits == SLOTS) full_ring_reports++;
    end
  endtask

  // Compare one result item with the oldest expected report
  task automatic check_duty_report(input logic [OUT_DATA_W-1:0] data);
    duty_report_t want;
    if (duty_reports_q.size() == 0) begin
      report_mismatch($sformatf("result 0x%h with no query outstanding", data));
    end else begin
      want = duty_reports_q.pop_front();
      if (data[15:0] !== want.duty)
        report_mismatch($sformatf("duty_percent_q8 got %0d expected %0d",
                                  data[15:0], want.duty));
      if (data[35:16] !== want.total)
        report_mismatch($sformatf("airtime_total_ms got %0d expected %0d",
                                  data[35:16], want.total));
      if (data[40:36] !== want.hits)
        report_mismatch($sformatf("records_in_window got %0d expected %0d",
                                  data[40:36], want.hits));
      if (data[47:41] !== '0)
        report_mismatch($sformatf("padding bits got 0x%h", data[47:41]));
      reports_checked++;
    end
  endtask

  // Sender: predict on acceptance, then offer the next pending item or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_duty_item(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() != 0 && src_idle_pct != 0 &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap <= $urandom_range(0, 11);
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur_item = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_item.air, cur_item.now};
          s_axis_tuser  <= cur_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check results, stall in bursts, and hold off for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_duty_report(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_reqs != holds_done) begin
        holds_done <= holds_done + 1;
        hold_left <= RX_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap <= $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no item moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic kind, input logic [NOW_W-1:0] now,
                           input logic [AIR_W-1:0] air);
    tx_item_t it;
    it.kind = kind;
    it.now  = now;
    it.air  = air;
    pend_q.push_back(it);
  endtask

  // Write the window register; only called with the block idle
  task automatic write_window(input logic [NOW_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_setting = value;
    windows_tried++;
  endtask

  // Wait until every item is sent and every report has come, then let the block settle
  task automatic drain_block();
    do @(posedge clk);
    while (pend_q.size() != 0 || s_axis_tvalid || duty_reports_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: time advances in steps scaled to the window, with odd jumps
  task automatic queue_traffic(input int count, input logic [NOW_W-1:0] win);
    logic [NOW_W-1:0] span;
    logic [NOW_W-1:0] now;
    logic [AIR_W-1:0] air;
    logic             kind;
    int               r;
    span = (win >> 3) + 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        now = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(0, span);
        now = clock_ms;
      end
      kind = ($urandom_range(0, 99) < 55) ? KIND_RECORD : KIND_QUERY;
      r = $urandom_range(0, 99);
      if (r < 10)      air = '0;
      else if (r < 20) air = '1;
      else if (r < 60) air = AIR_W'($urandom_range(0, 1000));
      else             air = AIR_W'($urandom);
      push_item(kind, now, air);
    end
  endtask

  initial begin
    logic [NOW_W-1:0] win;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring, wrap of the age, window boundary, ring wrap
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    push_item(KIND_QUERY,  32'd0, 16'hFFFF);
    push_item(KIND_RECORD, 32'd0, 16'h0000);
    push_item(KIND_RECORD, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(KIND_QUERY,  32'hFFFF_FFFF, 16'h0000);
    push_item(KIND_QUERY,  32'd0, 16'h1234);
    push_item(KIND_QUERY,  WINDOW_RESET, 16'h0000);
    push_item(KIND_QUERY,  WINDOW_RESET + 32'd1, 16'h0000);
    for (int i = 0; i < SLOTS; i++)
      push_item(KIND_RECORD, 32'd100 * i, 16'h0001 << i);
    push_item(KIND_QUERY, 32'd2000, 16'hFFFF);
    push_item(KIND_QUERY, 32'h8000_0000, 16'h0000);
    drain_block();

    // Random phases over several window settings, the extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       win = 32'd1;
        1:       win = 32'd0;
        2:       win = 32'hFFFF_FFFF;
        3:       win = WINDOW_RESET;
        4:       win = $urandom_range(1000, 100000);
        5:       win = $urandom;
        default: win = 32'd60000;
      endcase
      src_idle_pct  = (p == PHASES - 1 || p % 3 == 1) ? 0 : $urandom_range(10, 40);
      sink_idle_pct = (p == PHASES - 1 || p % 3 == 2) ? 0 : $urandom_range(10, 40);
      write_window(win);
      queue_traffic((p < 2) ? 60 : (p == 2) ? 100 : (p == PHASES - 1) ? 180 : 140, win);
      // Starve the result side so queries back up into the input
      if (p == 3) hold_reqs++;
      drain_block();
    end

    $display("covered %0d records and %0d queries over %0d window settings, %0d reports checked",
             records_taken, queries_taken, windows_tried, reports_checked);
    $display("reports: %0d saturated, %0d with nothing in window, %0d with a full ring in window",
             sat_reports, empty_reports, full_ring_reports);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/adct_pkg.sv
hdl/adct_ctrl.sv
hdl/adct_datapath.sv
hdl/airtime_duty_cycle_tracker_top.sv
tb/tb_airtime_duty_cycle_tracker_top.sv
